/* hdl/fbcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbcp_pkg
// Types, constants and the bank locate function of the flash byte
// coalescing programmer.
// ----------------------------------------------------------------------------
package fbcp_pkg;

  localparam int PAGE_BYTES     = 2048;
  localparam int PAGES_PER_BANK = 128;
  localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
  localparam int PAGE_IDX_W     = (PAGES_PER_BANK > 1) ? $clog2(PAGES_PER_BANK) : 1;
  localparam int MAP_SIZE       = 2 * PAGES_PER_BANK;
  localparam int MAP_IDX_W      = $clog2(MAP_SIZE);
  localparam logic [32:0] BANK_SPAN = 33'(PAGES_PER_BANK * PAGE_BYTES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] BANK1_RESET = 32'h0800_0000;
  localparam logic [31:0] BANK2_RESET = 32'h0804_0000;
  localparam logic [63:0] KEY_PAIR    = {32'hCDEF_89AB, 32'h4567_0123};
  localparam logic [63:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK1 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK2 = 1'd1;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_LOCK   = 2'd1;
  localparam logic [1:0] REQ_UNLOCK = 2'd2;

  typedef enum logic [2:0] {
    CMD_ACK     = 3'd0,
    CMD_ERASE   = 3'd1,
    CMD_PROGRAM = 3'd2,
    CMD_KEYS    = 3'd3,
    CMD_LOCK    = 3'd4
  } fbcp_cmd_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] byte_address;
    logic [7:0]  byte_value;
  } fbcp_req_t;

  typedef struct packed {
    fbcp_cmd_e   command;
    logic        bank_select;
    logic [6:0]  page_number;
    logic [31:0] word_address;
    logic [63:0] word_data;
    logic        status;
    logic        last;
  } fbcp_res_t;

  typedef struct packed {
    logic                  do_erase;
    logic                  erase_bank;
    logic [6:0]            erase_page;
    logic                  do_program;
    logic [31:0]           prog_addr;
    logic [63:0]           prog_data;
    fbcp_cmd_e             fin_cmd;
    logic                  fin_status;
  } fbcp_job_t;

  typedef struct packed {
    logic                  hit;
    logic                  bank;
    logic [PAGE_IDX_W-1:0] page;
  } fbcp_loc_t;

  function automatic fbcp_loc_t fbcp_locate(logic [31:0] a, logic [31:0] b1,
                                            logic [31:0] b2);
    fbcp_loc_t   l;
    logic [31:0] d1;
    logic [31:0] d2;
    d1 = a - b1;
    d2 = a - b2;
    l  = '0;
    if (a >= b1 && {1'b0, d1} < BANK_SPAN) begin
      l.hit  = 1'b1;
      l.bank = 1'b0;
      l.page = d1[PAGE_SHIFT +: PAGE_IDX_W];
    end else if (a >= b2 && {1'b0, d2} < BANK_SPAN) begin
      l.hit  = 1'b1;
      l.bank = 1'b1;
      l.page = d2[PAGE_SHIFT +: PAGE_IDX_W];
    end
    return l;
  endfunction

endpackage
`default_nettype wire

/* hdl/fbcp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbcp_front
// Accepts requests, keeps the pending doubleword, erased map, lock flag and
// bank registers, and turns each request into one job for the back end.
// ----------------------------------------------------------------------------
module fbcp_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire [fbcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [31:0]                     cfg_data_i,
  input  wire                            accept_i,
  input  fbcp_pkg::fbcp_req_t            req_i,
  output fbcp_pkg::fbcp_job_t            job_o
);
  import fbcp_pkg::*;

  logic [31:0]          bank1_q, bank1_d;
  logic [31:0]          bank2_q, bank2_d;
  logic [63:0]          pend_data_q, pend_data_d;
  logic [7:0]           pend_mask_q, pend_mask_d;
  logic [28:0]          pend_widx_q, pend_widx_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [MAP_SIZE-1:0]  map_q, map_d;
  logic                 locked_q, locked_d;

  fbcp_loc_t            loc_a, loc_o, loc_n, flush_loc;
  logic [31:0]          old_addr, new_addr, flush_addr;
  logic [63:0]          flush_data, base_data, merged_data, byte_mask;
  logic [7:0]           base_mask, merged_mask;
  logic [5:0]           shift;
  logic                 diff, flush_en;
  logic [MAP_IDX_W-1:0] map_idx;
  fbcp_job_t            job;

  assign old_addr = {pend_widx_q, 3'b000};
  assign new_addr = {req_i.byte_address[31:3], 3'b000};
  assign loc_a    = fbcp_locate(req_i.byte_address, bank1_q, bank2_q);
  assign loc_o    = fbcp_locate(old_addr, bank1_q, bank2_q);
  assign loc_n    = fbcp_locate(new_addr, bank1_q, bank2_q);

  assign diff        = pend_valid_q && (req_i.byte_address[31:3] != pend_widx_q);
  assign base_data   = diff ? ERASED_WORD : pend_data_q;
  assign base_mask   = diff ? 8'h00 : pend_mask_q;
  assign shift       = {req_i.byte_address[2:0], 3'b000};
  assign byte_mask   = 64'hFF << shift;
  assign merged_data = (base_data & ~byte_mask) | (64'(req_i.byte_value) << shift);
  assign merged_mask = base_mask | (8'h01 << req_i.byte_address[2:0]);

  always_comb begin
    bank1_d      = bank1_q;
    bank2_d      = bank2_q;
    pend_data_d  = pend_data_q;
    pend_mask_d  = pend_mask_q;
    pend_widx_d  = pend_widx_q;
    pend_valid_d = pend_valid_q;
    map_d        = map_q;
    locked_d     = locked_q;
    job          = '0;
    job.fin_cmd  = CMD_ACK;
    flush_en     = 1'b0;
    flush_addr   = old_addr;
    flush_data   = pend_data_q;
    flush_loc    = loc_o;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BANK1: bank1_d = cfg_data_i;
        CFG_BANK2: bank2_d = cfg_data_i;
        default: ;
      endcase
    end

    case (req_i.req_type)
      REQ_WRITE: begin
        if (!loc_a.hit) begin
          job.fin_status = 1'b1;
        end else begin
          if (diff) begin
            flush_en = 1'b1;
          end
          if (merged_mask == 8'hFF) begin
            flush_en     = 1'b1;
            flush_addr   = new_addr;
            flush_data   = merged_data;
            flush_loc    = loc_n;
            pend_data_d  = ERASED_WORD;
            pend_mask_d  = '0;
            pend_widx_d  = '0;
            pend_valid_d = 1'b0;
          end else begin
            pend_data_d  = merged_data;
            pend_mask_d  = merged_mask;
            pend_widx_d  = req_i.byte_address[31:3];
            pend_valid_d = 1'b1;
          end
        end
      end
      REQ_LOCK: begin
        if (!locked_q) begin
          flush_en     = pend_valid_q;
          pend_data_d  = ERASED_WORD;
          pend_mask_d  = '0;
          pend_widx_d  = '0;
          pend_valid_d = 1'b0;
          locked_d     = 1'b1;
          job.fin_cmd  = CMD_LOCK;
        end
      end
      REQ_UNLOCK: begin
        map_d        = '0;
        pend_data_d  = ERASED_WORD;
        pend_mask_d  = '0;
        pend_widx_d  = '0;
        pend_valid_d = 1'b0;
        locked_d     = 1'b0;
        job.fin_cmd  = locked_q ? CMD_KEYS : CMD_ACK;
      end
      default: ;
    endcase

    map_idx = MAP_IDX_W'(flush_loc.bank ? PAGES_PER_BANK : 0) + MAP_IDX_W'(flush_loc.page);
    if (flush_en) begin
      job.do_program = 1'b1;
      job.prog_addr  = flush_addr;
      job.prog_data  = flush_data;
      if (flush_loc.hit && !map_q[map_idx]) begin
        job.do_erase   = 1'b1;
        job.erase_bank = flush_loc.bank;
        job.erase_page = 7'(flush_loc.page);
        map_d[map_idx] = 1'b1;
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank1_q      <= BANK1_RESET;
      bank2_q      <= BANK2_RESET;
      pend_data_q  <= ERASED_WORD;
      pend_mask_q  <= '0;
      pend_widx_q  <= '0;
      pend_valid_q <= 1'b0;
      map_q        <= '0;
      locked_q     <= 1'b1;
    end else begin
      bank1_q <= bank1_d;
      bank2_q <= bank2_d;
      if (accept_i) begin
        pend_data_q  <= pend_data_d;
        pend_mask_q  <= pend_mask_d;
        pend_widx_q  <= pend_widx_d;
        pend_valid_q <= pend_valid_d;
        map_q        <= map_d;
        locked_q     <= locked_d;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/fbcp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbcp_queue
// Short job queue between the front end and the command sequencer.
// ----------------------------------------------------------------------------
module fbcp_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  fbcp_pkg::fbcp_job_t  push_job_i,
  input  wire                  pop_i,
  output fbcp_pkg::fbcp_job_t  head_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import fbcp_pkg::*;

  fbcp_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/fbcp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbcp_back
// Command sequencer: expands the head job into erase, program and final
// commands into the output register, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module fbcp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  fbcp_pkg::fbcp_job_t  head_i,
  input  wire                  empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fbcp_pkg::fbcp_res_t  out_res_o
);
  import fbcp_pkg::*;

  typedef enum logic [1:0] {
    ST_ERASE,
    ST_PROGRAM,
    ST_FINAL
  } step_e;

  step_e     step_q, step_d, cur;
  logic      out_valid_q, out_valid_d;
  fbcp_res_t out_q, out_d;
  logic      load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    cur = step_q;
    if (cur == ST_ERASE && !head_i.do_erase) begin
      cur = ST_PROGRAM;
    end
    if (cur == ST_PROGRAM && !head_i.do_program) begin
      cur = ST_FINAL;
    end

    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;

    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = '0;
        case (cur)
          ST_ERASE: begin
            out_d.command     = CMD_ERASE;
            out_d.bank_select = head_i.erase_bank;
            out_d.page_number = head_i.erase_page;
            step_d            = ST_PROGRAM;
          end
          ST_PROGRAM: begin
            out_d.command      = CMD_PROGRAM;
            out_d.word_address = head_i.prog_addr;
            out_d.word_data    = head_i.prog_data;
            step_d             = ST_FINAL;
          end
          default: begin
            out_d.command   = head_i.fin_cmd;
            out_d.status    = head_i.fin_status;
            out_d.word_data = (head_i.fin_cmd == CMD_KEYS) ? KEY_PAIR : '0;
            out_d.last      = 1'b1;
            step_d          = ST_ERASE;
            pop_o           = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_ERASE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
`default_nettype wire

/* hdl/flash_byte_coalescing_programmer_unit.sv */
`default_nettype none
// Path: accepted requests are queued; their commands leave an output register.
// Throughput: a request yields one to three commands, one per cycle from the
// command sequencer while the output is not stalled; the front end takes a
// request every cycle while the two-entry job queue has room.
// Reset: bank bases to their defaults, pending word and erased map cleared,
// flash locked; no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
// flash_byte_coalescing_programmer_unit
// Collects byte writes into doublewords and issues erase, program, unlock
// and lock commands for the flash controller.
// ----------------------------------------------------------------------------
module flash_byte_coalescing_programmer_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [fbcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [31:0]                     cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  fbcp_pkg::fbcp_req_t            in_req_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output fbcp_pkg::fbcp_res_t            out_res_o
);
  import fbcp_pkg::*;

  fbcp_job_t front_job, head_job;
  logic      accept, q_empty, q_full, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  fbcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .req_i       (in_req_i),
    .job_o       (front_job)
  );

  fbcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (front_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  fbcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule
`default_nettype wire

/* tb/fbcp_command_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbcp_command_checker
// Watches the register, request and command channels of the byte
// coalescing programmer. Keeps its own copy of the bank bases, the pending
// doubleword, the erased-page map and the lock flag. Predicts the command
// sequence of every accepted request and compares each accepted command
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fbcp_command_checker
  import fbcp_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [31:0]           cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  fbcp_req_t            in_req_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  fbcp_res_t            out_res_i,
  output int                   fail_count_o,
  output int                   open_cmds_o
);

  localparam logic [32:0] SPAN = 33'(PAGES_PER_BANK) * 33'(PAGE_BYTES);

  logic [31:0]         bank1_base;
  logic [31:0]         bank2_base;
  logic [63:0]         word_buf;
  logic [7:0]          byte_mask;
  logic [28:0]         word_idx;
  logic                word_open;
  logic [MAP_SIZE-1:0] erased_pages;
  logic                locked;

  fbcp_res_t cmd_queue[$];
  fbcp_res_t step_cmds[$];

  function automatic fbcp_res_t make_cmd(input fbcp_cmd_e c, input logic b,
                                         input logic [6:0] p, input logic [31:0] a,
                                         input logic [63:0] d, input logic s);
    fbcp_res_t r;
    r.command      = c;
    r.bank_select  = b;
    r.page_number  = p;
    r.word_address = a;
    r.word_data    = d;
    r.status       = s;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic find_page(input logic [31:0] a, output logic bank,
                                     output logic [6:0] page);
    logic [31:0] d1;
    logic [31:0] d2;
    logic        hit;
    d1   = a - bank1_base;
    d2   = a - bank2_base;
    bank = 1'b0;
    page = '0;
    hit  = 1'b0;
    if (a >= bank1_base && {1'b0, d1} < SPAN) begin
      hit  = 1'b1;
      page = 7'(d1 / PAGE_BYTES);
    end else if (a >= bank2_base && {1'b0, d2} < SPAN) begin
      hit  = 1'b1;
      bank = 1'b1;
      page = 7'(d2 / PAGE_BYTES);
    end
    return hit;
  endfunction

  task automatic clear_word();
    word_buf  = ERASED_WORD;
    byte_mask = '0;
    word_idx  = '0;
    word_open = 1'b0;
  endtask

  task automatic flush_word();
    logic [31:0] addr;
    logic        bank;
    logic [6:0]  page;
    int          idx;
    addr = {word_idx, 3'b000};
    if (find_page(addr, bank, page)) begin
      idx = int'(bank) * PAGES_PER_BANK + int'(page);
      if (!erased_pages[idx]) begin
        step_cmds.push_back(make_cmd(CMD_ERASE, bank, page, '0, '0, 1'b0));
        erased_pages[idx] = 1'b1;
      end
    end
    step_cmds.push_back(make_cmd(CMD_PROGRAM, 1'b0, '0, addr, word_buf, 1'b0));
    clear_word();
  endtask

  task automatic predict_commands(input fbcp_req_t r);
    logic       bank;
    logic [6:0] page;
    logic [2:0] lane;
    fbcp_res_t  c;
    step_cmds.delete();
    case (r.req_type)
      REQ_WRITE: begin
        if (!find_page(r.byte_address, bank, page)) begin
          step_cmds.push_back(make_cmd(CMD_ACK, 1'b0, '0, '0, '0, 1'b1));
        end else begin
          if (word_open && r.byte_address[31:3] != word_idx) flush_word();
          lane                  = r.byte_address[2:0];
          word_idx              = r.byte_address[31:3];
          word_open             = 1'b1;
          word_buf[lane*8 +: 8] = r.byte_value;
          byte_mask[lane]       = 1'b1;
          if (byte_mask == 8'hFF) flush_word();
          step_cmds.push_back(make_cmd(CMD_ACK, 1'b0, '0, '0, '0, 1'b0));
        end
      end
      REQ_LOCK: begin
        if (locked) begin
          step_cmds.push_back(make_cmd(CMD_ACK, 1'b0, '0, '0, '0, 1'b0));
        end else begin
          if (word_open) flush_word();
          step_cmds.push_back(make_cmd(CMD_LOCK, 1'b0, '0, '0, '0, 1'b0));
          locked = 1'b1;
        end
      end
      REQ_UNLOCK: begin
        erased_pages = '0;
        clear_word();
        if (locked) begin
          step_cmds.push_back(make_cmd(CMD_KEYS, 1'b0, '0, '0, KEY_PAIR, 1'b0));
          locked = 1'b0;
        end else begin
          step_cmds.push_back(make_cmd(CMD_ACK, 1'b0, '0, '0, '0, 1'b0));
        end
      end
      default: begin
        step_cmds.push_back(make_cmd(CMD_ACK, 1'b0, '0, '0, '0, 1'b0));
      end
    endcase
    foreach (step_cmds[i]) begin
      c      = step_cmds[i];
      c.last = (i == step_cmds.size() - 1);
      cmd_queue.push_back(c);
    end
  endtask

  task automatic note_failure(input string what, input fbcp_res_t want,
                              input fbcp_res_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t %s", $realtime, what);
      $display("  expected cmd=%0d bank=%0d page=%0d addr=%h data=%h status=%0d last=%0d",
               want.command, want.bank_select, want.page_number, want.word_address,
               want.word_data, want.status, want.last);
      $display("  actual   cmd=%0d bank=%0d page=%0d addr=%h data=%h status=%0d last=%0d",
               got.command, got.bank_select, got.page_number, got.word_address,
               got.word_data, got.status, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fbcp_res_t want;
    if (!rst_ni) begin
      bank1_base   = BANK1_RESET;
      bank2_base   = BANK2_RESET;
      clear_word();
      erased_pages = '0;
      locked       = 1'b1;
      cmd_queue.delete();
      fail_count_o = 0;
      open_cmds_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cmd_queue.size() == 0) begin
          note_failure("command with no request behind it", '0, out_res_i);
        end else begin
          want = cmd_queue.pop_front();
          if (out_res_i.command      !== want.command      ||
              out_res_i.bank_select  !== want.bank_select  ||
              out_res_i.page_number  !== want.page_number  ||
              out_res_i.word_address !== want.word_address ||
              out_res_i.word_data    !== want.word_data    ||
              out_res_i.status       !== want.status       ||
              out_res_i.last         !== want.last)
            note_failure("command mismatch", want, out_res_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_commands(in_req_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_BANK1) bank1_base = cfg_data_i;
        else if (cfg_index_i == CFG_BANK2) bank2_base = cfg_data_i;
      end
      open_cmds_o = cmd_queue.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Top of the byte coalescing programmer bench. Sends a directed list of
// requests and then random write sequences, locks and unlocks in bursts
// under several bank base settings, with a randomly stalling command sink.
// The checker beside the block predicts and compares every command.
// ----------------------------------------------------------------------------
module testbench;
  import fbcp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_ITEMS  = 54;
  localparam int WORDS_PER_PG = PAGE_BYTES / 8;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  fbcp_req_t            in_req_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  fbcp_res_t            out_res_o;

  int                   fail_count;
  int                   open_cmds;
  int                   idle_cycles;
  logic [31:0]          bank1_now;
  logic [31:0]          bank2_now;
  fbcp_req_t            req_backlog[$];

  flash_byte_coalescing_programmer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  fbcp_command_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_i    (out_res_o),
    .fail_count_o (fail_count),
    .open_cmds_o  (open_cmds)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pct;
    int hold;
    int mode;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      case (mode)
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 85;
      endcase
      hold = $urandom_range(16, 160);
      for (int i = 0; i < hold; i++) begin
        @(negedge clk_i);
        if (mode == 4) out_stall_i <= i[0];
        else out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic fbcp_req_t make_req(input logic [1:0] t, input logic [31:0] a,
                                         input logic [7:0] v);
    fbcp_req_t r;
    r.req_type     = t;
    r.byte_address = a;
    r.byte_value   = v;
    return r;
  endfunction

  function automatic logic [31:0] bank_address(input bit hi_bank, input int page,
                                               input int word, input int lane);
    return (hi_bank ? bank2_now : bank1_now) + 32'(page * PAGE_BYTES) + 32'(word * 8 + lane);
  endfunction

  function automatic int pick_page();
    return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                      : $urandom_range(0, PAGES_PER_BANK - 1);
  endfunction

  function automatic int pick_word();
    return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                      : $urandom_range(0, WORDS_PER_PG - 1);
  endfunction

  task automatic add_write(input logic [31:0] a);
    req_backlog.push_back(make_req(REQ_WRITE, a, 8'($urandom)));
  endtask

  task automatic add_sequence();
    int  kind;
    bit  hi_bank;
    int  page;
    int  word;
    int  lanes[8];
    int  j;
    int  tmp;
    int  n;
    kind    = $urandom_range(0, 99);
    hi_bank = 1'($urandom_range(0, 1));
    page    = pick_page();
    word    = pick_word();
    if (kind < 35) begin
      foreach (lanes[i]) lanes[i] = i;
      for (int i = 7; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = lanes[i];
        lanes[i] = lanes[j];
        lanes[j] = tmp;
      end
      foreach (lanes[i]) add_write(bank_address(hi_bank, page, word, lanes[i]));
    end else if (kind < 60) begin
      n = $urandom_range(1, 7);
      repeat (n) add_write(bank_address(hi_bank, page, word, $urandom_range(0, 7)));
    end else if (kind < 72) begin
      add_write(bank_address(hi_bank, $urandom_range(0, PAGES_PER_BANK - 1),
                             $urandom_range(0, WORDS_PER_PG - 1), $urandom_range(0, 7)));
    end else if (kind < 80) begin
      add_write($urandom);
    end else if (kind < 88) begin
      req_backlog.push_back(make_req(REQ_LOCK, $urandom, 8'($urandom)));
    end else if (kind < 95) begin
      req_backlog.push_back(make_req(REQ_UNLOCK, $urandom, 8'($urandom)));
    end else begin
      req_backlog.push_back(make_req(REQ_SPARE, $urandom, 8'($urandom)));
    end
  endtask

  task automatic send_request(input fbcp_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_backlog();
    int burst;
    int gap;
    while (req_backlog.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      while (burst > 0 && req_backlog.size() > 0) begin
        send_request(req_backlog.pop_front());
        burst--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        in_req_i   <= make_req(2'($urandom), $urandom, 8'($urandom));
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (open_cmds != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_banks(input logic [31:0] b1, input logic [31:0] b2);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_BANK1;
    cfg_data_i  <= b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= CFG_BANK2;
    cfg_data_i  <= b2;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    bank1_now = b1;
    bank2_now = b2;
  endtask

  task automatic run_random(input int count);
    while (req_backlog.size() < count) add_sequence();
    send_backlog();
    wait_idle();
  endtask

  initial begin
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    bank1_now   = BANK1_RESET;
    bank2_now   = BANK2_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    req_backlog.push_back(make_req(REQ_WRITE, 32'h0800_0000, 8'h00));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0800_0007, 8'hFF));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0807_FFFF, 8'hA5));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0000_0000, 8'h3C));
    req_backlog.push_back(make_req(REQ_WRITE, 32'hFFFF_FFFF, 8'h5A));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h07FF_FFFF, 8'hFF));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0808_0000, 8'h00));
    req_backlog.push_back(make_req(REQ_LOCK, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_UNLOCK, 32'hFFFF_FFFF, 8'hFF));
    req_backlog.push_back(make_req(REQ_UNLOCK, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_SPARE, 32'hFFFF_FFFF, 8'hFF));
    for (int i = 0; i < 8; i++) add_write(32'h0803_FFF8 + 32'(i));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0803_FFF0, 8'h81));
    req_backlog.push_back(make_req(REQ_LOCK, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_UNLOCK, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_LOCK, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_WRITE, 32'h0804_0800, 8'h7E));
    send_backlog();
    wait_idle();

    run_random(PHASE_ITEMS);
    set_banks(32'h0000_0000, 32'h0004_0000);
    run_random(PHASE_ITEMS);
    set_banks(32'hFFFF_FFFF, 32'hFFFC_0000);
    run_random(PHASE_ITEMS);
    set_banks(32'h2000_0000, 32'h2002_0000);
    run_random(PHASE_ITEMS);
    set_banks(32'h1000_0003, 32'h3000_1005);
    run_random(PHASE_ITEMS);
    set_banks($urandom, $urandom);
    run_random(PHASE_ITEMS);
    set_banks(BANK1_RESET, BANK2_RESET);
    run_random(PHASE_ITEMS);

    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && open_cmds == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fbcp_pkg.sv
hdl/fbcp_front.sv
hdl/fbcp_queue.sv
hdl/fbcp_back.sv
hdl/flash_byte_coalescing_programmer_unit.sv
tb/fbcp_command_checker.sv
tb/testbench.sv
